### hdl/csor_pkg.sv
package csor_pkg;

  typedef enum logic [1:0] {
    KIND_CIRCLE = 2'd0,
    KIND_BOX    = 2'd1,
    KIND_TOP    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    MODE_DIRECT = 3'd0,
    MODE_SCALE  = 3'd1,
    MODE_TOP    = 3'd2,
    MODE_CORNER = 3'd3,
    MODE_DIV    = 3'd4
  } mode_t;

  localparam int unsigned ROOT_BITS = 27;
  localparam int unsigned QUOT_BITS = 21;
  localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;

  typedef struct packed {
    logic              vld;
    mode_t             mode;
    logic              hit;
    logic signed [23:0] dpx;
    logic signed [23:0] dpy;
    logic              sx;
    logic              sy;
    logic [25:0]       mx;
    logic [25:0]       my;
    logic [20:0]       base;
    logic [20:0]       cmp;
    logic              oh_neg;
    logic              ov_neg;
  } ctl_t;

endpackage

### hdl/circle_shape_overlap_resolver_unit.sv
// Fully pipelined: one shape pair is accepted every cycle and busy is always low.
// Most of the pipeline depth lies in the 27-stage square root and the 21-stage divider
// that scales the push vector.
// Synchronous active-low reset clears only the valid bits of the pipeline.
// The receiver cannot stall, so results are presented for exactly one cycle.
module circle_shape_overlap_resolver_unit #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic signed [23:0] in_own_x,
  input  logic signed [23:0] in_own_y,
  input  logic [19:0]        in_own_radius,
  input  logic signed [23:0] in_other_x,
  input  logic signed [23:0] in_other_y,
  input  logic [19:0]        in_other_radius,
  input  logic [19:0]        in_other_half_width,
  input  logic [19:0]        in_other_half_height,
  output logic               out_valid,
  output logic               out_collided,
  output logic signed [23:0] out_push_x,
  output logic signed [23:0] out_push_y
);

  localparam int unsigned NR = csor_pkg::ROOT_BITS;
  localparam int unsigned NQ = csor_pkg::QUOT_BITS;
  localparam int unsigned LATENCY = NR + NQ + 6;
  localparam logic signed [26:0] ONE = 27'(1) << FRAC_BITS;

  function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
    if (v > 28'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -28'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic [25:0] mag27(input logic signed [26:0] v);
    logic signed [26:0] n;
    n = -v;
    return v[26] ? n[25:0] : v[25:0];
  endfunction

  // Passes a stage's control word on, with its valid bit cleared in reset.
  function automatic csor_pkg::ctl_t gate_vld(input csor_pkg::ctl_t c, input logic en);
    csor_pkg::ctl_t g;
    g = c;
    g.vld = c.vld & en;
    return g;
  endfunction

  assign busy = 1'b0;

  // Stage 0: differences, box regions and per-kind routing.
  logic signed [24:0] dx, dy, dyt;
  logic [24:0]        adx, ady;
  logic signed [26:0] pxv, pyv, pxw, pyw, ex, ey, hoff, voff, ax, ay, topv;
  logic [20:0]        tot;
  logic               oh_lo, oh_hi, ov_lo, ov_hi, top_side;
  csor_pkg::ctl_t     c0_nxt, c0_r, c1_r;

  always_comb begin
    dx  = {in_own_x[23], in_own_x} - {in_other_x[23], in_other_x};
    dy  = {in_own_y[23], in_own_y} - {in_other_y[23], in_other_y};
    dyt = -dy;
    adx = dx[24] ? 25'(-dx) : 25'(dx);
    ady = dy[24] ? 25'(-dy) : 25'(dy);
    pxv = $signed({7'b0, in_other_half_width}) + $signed({7'b0, in_own_radius})
          - $signed({2'b0, adx});
    pyv = $signed({7'b0, in_other_half_height}) + $signed({7'b0, in_own_radius})
          - $signed({2'b0, ady});
    pxw = pxv & ~(ONE - 27'sd1);
    pyw = pyv & ~(ONE - 27'sd1);
    oh_lo = ($signed({{2{dx[24]}}, dx}) + $signed({7'b0, in_other_half_width})) < 27'sd0;
    oh_hi = $signed({7'b0, in_other_half_width}) < $signed({{2{dx[24]}}, dx});
    ov_lo = ($signed({{2{dy[24]}}, dy}) + $signed({7'b0, in_other_half_height})) < 27'sd0;
    ov_hi = $signed({7'b0, in_other_half_height}) < $signed({{2{dy[24]}}, dy});
    hoff = oh_hi ? $signed({7'b0, in_other_half_width})
         : (oh_lo ? -$signed({7'b0, in_other_half_width}) : 27'sd0);
    voff = ov_hi ? $signed({7'b0, in_other_half_height})
         : (ov_lo ? -$signed({7'b0, in_other_half_height}) : 27'sd0);
    ex = $signed({{2{dx[24]}}, dx}) - hoff - ONE;
    ey = $signed({{2{dy[24]}}, dy}) - voff - ONE;
    tot = {1'b0, in_own_radius} + {1'b0, in_other_radius};
    top_side = $signed({in_other_y[23], in_other_y[23], in_other_y, 1'b0})
             > ($signed({in_own_y[23], in_own_y[23], in_own_y, 1'b0})
                - $signed({7'b0, in_own_radius}));
    topv = $signed({{3{in_own_y[23]}}, in_own_y}) - $signed({{3{in_other_y[23]}}, in_other_y})
         + $signed({7'b0, in_other_radius});
    ax = $signed({{2{dx[24]}}, dx});
    ay = $signed({{2{dy[24]}}, dy});

    c0_nxt        = '0;
    c0_nxt.vld    = start;
    c0_nxt.mode   = csor_pkg::MODE_DIRECT;
    c0_nxt.base   = tot;
    c0_nxt.cmp    = tot;
    c0_nxt.oh_neg = oh_lo;
    c0_nxt.ov_neg = ov_lo;
    unique case (csor_pkg::kind_t'(in_kind))
      csor_pkg::KIND_CIRCLE: begin
        c0_nxt.mode = csor_pkg::MODE_SCALE;
        c0_nxt.hit  = 1'b1;
      end
      csor_pkg::KIND_TOP: begin
        ax = -ax;
        ay = -ay;
        if (top_side) begin
          c0_nxt.mode = csor_pkg::MODE_TOP;
          c0_nxt.cmp  = {1'b0, in_other_radius};
          c0_nxt.hit  = 1'b1;
          c0_nxt.dpy  = sat24({topv[26], topv});
        end else begin
          c0_nxt.mode = csor_pkg::MODE_SCALE;
          c0_nxt.hit  = dyt > 25'sd0;
        end
      end
      csor_pkg::KIND_BOX: begin
        if (pxv >= ONE && pyv >= ONE) begin
          if (!oh_lo && !oh_hi && !ov_lo && !ov_hi) begin
            c0_nxt.hit = 1'b1;
            if (pxw < pyw) begin
              c0_nxt.dpx = dx[24] ? sat24(-{pxw[26], pxw}) : sat24({pxw[26], pxw});
            end else begin
              c0_nxt.dpy = dy[24] ? sat24(-{pyw[26], pyw}) : sat24({pyw[26], pyw});
            end
          end else if (!oh_lo && !oh_hi) begin
            c0_nxt.hit = 1'b1;
            c0_nxt.dpy = ov_lo ? sat24(-{pyw[26], pyw}) : sat24({pyw[26], pyw});
          end else if (!ov_lo && !ov_hi) begin
            c0_nxt.hit = 1'b1;
            c0_nxt.dpx = oh_lo ? sat24(-{pxw[26], pxw}) : sat24({pxw[26], pxw});
          end else begin
            c0_nxt.mode = csor_pkg::MODE_CORNER;
            c0_nxt.base = {1'b0, in_own_radius};
            ax = ex;
            ay = ey;
          end
        end
      end
      default: begin
      end
    endcase
    c0_nxt.sx = ax[26];
    c0_nxt.sy = ay[26];
    c0_nxt.mx = mag27(ax);
    c0_nxt.my = mag27(ay);
  end

  // Stage 1: squares.
  logic [51:0] sqx_r, sqy_r;
  logic [41:0] cmp2_r;

  always_ff @(posedge clk) begin
    c0_r <= gate_vld(c0_nxt, rst_n);
    c1_r <= gate_vld(c0_r, rst_n);
    sqx_r <= c0_r.mx * c0_r.mx;
    sqy_r <= c0_r.my * c0_r.my;
    cmp2_r <= c0_r.cmp * c0_r.cmp;
  end

  // Stage 2: squared length and radius compares.
  logic [52:0]    sum;
  logic           lt;
  csor_pkg::ctl_t c2_nxt;

  always_comb begin
    sum    = {1'b0, sqx_r} + {1'b0, sqy_r};
    lt     = sum < {11'b0, cmp2_r};
    c2_nxt = c1_r;
    if (c1_r.mode == csor_pkg::MODE_SCALE) begin
      c2_nxt.hit = c1_r.hit & lt;
    end else if (c1_r.mode == csor_pkg::MODE_TOP) begin
      c2_nxt.hit  = c1_r.hit & lt;
      c2_nxt.mode = csor_pkg::MODE_DIRECT;
    end
  end

  // Square root, one result bit per stage.
  csor_pkg::ctl_t sq_c_r [NR+1];
  logic [53:0]    sq_v_r [NR+1];
  logic [53:0]    sq_res_r [NR+1];

  always_ff @(posedge clk) begin
    sq_c_r[0]   <= gate_vld(c2_nxt, rst_n);
    sq_v_r[0]   <= {1'b0, sum};
    sq_res_r[0] <= '0;
  end

  for (genvar k = 0; k < NR; k++) begin : g_sqrt
    localparam logic [53:0] BIT = 54'(1) << (2 * (NR - 1 - k));
    logic [53:0] trial;
    assign trial = sq_res_r[k] + BIT;
    always_ff @(posedge clk) begin
      sq_c_r[k+1] <= gate_vld(sq_c_r[k], rst_n);
      if (sq_v_r[k] >= trial) begin
        sq_v_r[k+1]   <= sq_v_r[k] - trial;
        sq_res_r[k+1] <= (sq_res_r[k] >> 1) + BIT;
      end else begin
        sq_v_r[k+1]   <= sq_v_r[k];
        sq_res_r[k+1] <= sq_res_r[k] >> 1;
      end
    end
  end

  // Target length and final collision decision for the corner case.
  logic [NR-1:0]      len;
  logic signed [27:0] pen;
  csor_pkg::ctl_t     p_nxt, p_c_r;
  logic [20:0]        p_tgt_r;
  logic [NR-1:0]      p_len_r;

  always_comb begin
    len   = sq_res_r[NR][NR-1:0];
    pen   = $signed({7'b0, sq_c_r[NR].base}) - $signed({1'b0, len});
    p_nxt = sq_c_r[NR];
    if (sq_c_r[NR].mode == csor_pkg::MODE_SCALE) begin
      p_nxt.mode = (sq_c_r[NR].hit && len != '0) ? csor_pkg::MODE_DIV
                                                 : csor_pkg::MODE_DIRECT;
    end else if (sq_c_r[NR].mode == csor_pkg::MODE_CORNER) begin
      p_nxt.hit = pen > 28'sd0;
      if (len != '0) begin
        p_nxt.mode = csor_pkg::MODE_DIV;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_c_r   <= gate_vld(p_nxt, rst_n);
    p_tgt_r <= pen[20:0];
    p_len_r <= len;
  end

  // Products for the scaling and the diagonal corner push.
  localparam logic [15:0] INV_SQRT2 = csor_pkg::INV_SQRT2_Q16;

  logic [36:0]    diag;
  logic [20:0]    m;
  csor_pkg::ctl_t m_nxt;

  always_comb begin
    diag  = p_tgt_r * INV_SQRT2;
    m     = diag[36:16];
    m_nxt = p_c_r;
    if (p_c_r.mode == csor_pkg::MODE_CORNER) begin
      m_nxt.mode = csor_pkg::MODE_DIRECT;
      m_nxt.dpx  = p_c_r.oh_neg ? -$signed({3'b0, m}) : $signed({3'b0, m});
      m_nxt.dpy  = p_c_r.ov_neg ? -$signed({3'b0, m}) : $signed({3'b0, m});
    end
  end

  // Restoring divider, one quotient bit per stage for each axis.
  csor_pkg::ctl_t dv_c_r [NQ+1];
  logic [47:0]    dv_rx_r [NQ+1];
  logic [47:0]    dv_ry_r [NQ+1];
  logic [NQ-1:0]  dv_qx_r [NQ+1];
  logic [NQ-1:0]  dv_qy_r [NQ+1];
  logic [NR-1:0]  dv_len_r [NQ+1];

  always_ff @(posedge clk) begin
    dv_c_r[0]   <= gate_vld(m_nxt, rst_n);
    dv_rx_r[0]  <= 48'(p_c_r.mx) * 48'(p_tgt_r);
    dv_ry_r[0]  <= 48'(p_c_r.my) * 48'(p_tgt_r);
    dv_qx_r[0]  <= '0;
    dv_qy_r[0]  <= '0;
    dv_len_r[0] <= p_len_r;
  end

  for (genvar j = 0; j < NQ; j++) begin : g_div
    logic [47:0] dsh;
    assign dsh = {21'b0, dv_len_r[j]} << (NQ - 1 - j);
    always_ff @(posedge clk) begin
      dv_c_r[j+1]   <= gate_vld(dv_c_r[j], rst_n);
      dv_len_r[j+1] <= dv_len_r[j];
      if (dv_rx_r[j] >= dsh) begin
        dv_rx_r[j+1] <= dv_rx_r[j] - dsh;
        dv_qx_r[j+1] <= {dv_qx_r[j][NQ-2:0], 1'b1};
      end else begin
        dv_rx_r[j+1] <= dv_rx_r[j];
        dv_qx_r[j+1] <= {dv_qx_r[j][NQ-2:0], 1'b0};
      end
      if (dv_ry_r[j] >= dsh) begin
        dv_ry_r[j+1] <= dv_ry_r[j] - dsh;
        dv_qy_r[j+1] <= {dv_qy_r[j][NQ-2:0], 1'b1};
      end else begin
        dv_ry_r[j+1] <= dv_ry_r[j];
        dv_qy_r[j+1] <= {dv_qy_r[j][NQ-2:0], 1'b0};
      end
    end
  end

  // Output register.
  csor_pkg::ctl_t     fc;
  logic signed [27:0] qx, qy;
  logic signed [23:0] px_nxt, py_nxt;
  logic               out_valid_r, out_collided_r;
  logic signed [23:0] out_push_x_r, out_push_y_r;

  always_comb begin
    fc = dv_c_r[NQ];
    qx = $signed({7'b0, dv_qx_r[NQ]});
    qy = $signed({7'b0, dv_qy_r[NQ]});
    px_nxt = '0;
    py_nxt = '0;
    if (fc.hit) begin
      if (fc.mode == csor_pkg::MODE_DIV) begin
        px_nxt = fc.sx ? sat24(-qx) : sat24(qx);
        py_nxt = fc.sy ? sat24(-qy) : sat24(qy);
      end else begin
        px_nxt = fc.dpx;
        py_nxt = fc.dpy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fc.vld;
    end
    out_collided_r <= fc.hit;
    out_push_x_r   <= px_nxt;
    out_push_y_r   <= py_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_collided = out_collided_r;
  assign out_push_x   = out_push_x_r;
  assign out_push_y   = out_push_y_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_valid)
    else $error("transaction did not produce a result after the pipeline latency");

  a_no_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_collided) |-> (out_push_x == 24'sd0 && out_push_y == 24'sd0))
    else $error("push vector nonzero without a collision");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (p_c_r.vld && p_c_r.mode == csor_pkg::MODE_DIV) |-> (p_len_r != '0))
    else $error("division scheduled with a zero length");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    csor_pkg::kind_t    kind;
    logic signed [23:0] own_x;
    logic signed [23:0] own_y;
    logic [19:0]        own_radius;
    logic signed [23:0] other_x;
    logic signed [23:0] other_y;
    logic [19:0]        other_radius;
    logic [19:0]        half_width;
    logic [19:0]        half_height;
  } pair_t;

  typedef struct {
    logic               collided;
    logic signed [23:0] push_x;
    logic signed [23:0] push_y;
  } push_t;

  localparam longint ONE = 256;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_kind = '0;
  logic signed [23:0] in_own_x = '0, in_own_y = '0, in_other_x = '0, in_other_y = '0;
  logic [19:0] in_own_radius = '0, in_other_radius = '0;
  logic [19:0] in_other_half_width = '0, in_other_half_height = '0;
  logic out_valid, out_collided;
  logic signed [23:0] out_push_x, out_push_y;

  pair_t pending_pairs[$];
  push_t expected_pushes[$];
  pair_t driven_pair;
  int idle_pct = 0;
  int errors = 0;
  int accepted = 0;
  int hits_seen = 0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  circle_shape_overlap_resolver_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_own_x(in_own_x), .in_own_y(in_own_y),
    .in_own_radius(in_own_radius), .in_other_x(in_other_x), .in_other_y(in_other_y),
    .in_other_radius(in_other_radius), .in_other_half_width(in_other_half_width),
    .in_other_half_height(in_other_half_height),
    .out_valid(out_valid), .out_collided(out_collided),
    .out_push_x(out_push_x), .out_push_y(out_push_y)
  );

  function automatic longint int_sqrt(longint v);
    longint root;
    longint bitv;
    root = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >>> 1) + bitv;
      end else begin
        root = root >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return root;
  endfunction

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic push_t predict_push(pair_t p);
    push_t r;
    longint ox, oy, tx, ty, orad, trad, hw, hh;
    longint dx, dy, tot, d2, len, pxw, pyw, ex, ey, pen, m, px, py;
    int oh, ov;
    logic hit;
    ox = p.own_x; oy = p.own_y; tx = p.other_x; ty = p.other_y;
    orad = p.own_radius; trad = p.other_radius; hw = p.half_width; hh = p.half_height;
    hit = 1'b0; px = 0; py = 0;
    case (p.kind)
      csor_pkg::KIND_CIRCLE: begin
        dx = ox - tx; dy = oy - ty; tot = orad + trad;
        d2 = dx * dx + dy * dy;
        if (d2 < tot * tot) begin
          hit = 1'b1;
          len = int_sqrt(d2);
          if (len > 0) begin
            px = (dx * (tot - len)) / len;
            py = (dy * (tot - len)) / len;
          end
        end
      end
      csor_pkg::KIND_BOX: begin
        dx = ox - tx; dy = oy - ty;
        // Penetration depths are cut to whole units before any test.
        pxw = ((hw + orad - mag(dx)) / ONE) * ONE;
        pyw = ((hh + orad - mag(dy)) / ONE) * ONE;
        if (pxw > 0 && pyw > 0) begin
          oh = (dx < -hw) ? -1 : ((hw < dx) ? 1 : 0);
          ov = (dy < -hh) ? -1 : ((hh < dy) ? 1 : 0);
          if (oh == 0 && ov == 0) begin
            hit = 1'b1;
            if (pxw < pyw) px = (dx < 0) ? -pxw : pxw;
            else py = (dy < 0) ? -pyw : pyw;
          end else if (oh == 0) begin
            hit = 1'b1;
            py = ov * pyw;
          end else if (ov == 0) begin
            hit = 1'b1;
            px = oh * pxw;
          end else begin
            ex = ox - (tx + oh * hw) - ONE;
            ey = oy - (ty + ov * hh) - ONE;
            len = int_sqrt(ex * ex + ey * ey);
            pen = orad - len;
            if (pen > 0) begin
              hit = 1'b1;
              if (len == 0) begin
                m = (pen * 46341) / 65536;
                px = oh * m;
                py = ov * m;
              end else begin
                px = (ex * pen) / len;
                py = (ey * pen) / len;
              end
            end
          end
        end
      end
      csor_pkg::KIND_TOP: begin
        dx = tx - ox; dy = ty - oy; tot = orad + trad;
        d2 = dx * dx + dy * dy;
        if (2 * ty > 2 * oy - orad) begin
          if (d2 < trad * trad) begin
            hit = 1'b1;
            py = oy - ty + trad;
          end
        end else if (d2 < tot * tot && dy > 0) begin
          hit = 1'b1;
          len = int_sqrt(d2);
          if (len > 0) begin
            px = (dx * (tot - len)) / len;
            py = (dy * (tot - len)) / len;
          end
        end
      end
      default: ;
    endcase
    r.collided = hit;
    r.push_x = clamp24(px);
    r.push_y = clamp24(py);
    return r;
  endfunction

  function automatic pair_t make_pair(csor_pkg::kind_t k, longint ox, longint oy, longint r,
                                      longint tx, longint ty, longint tr,
                                      longint hw, longint hh);
    pair_t p;
    p.kind = k; p.own_x = ox[23:0]; p.own_y = oy[23:0]; p.own_radius = r[19:0];
    p.other_x = tx[23:0]; p.other_y = ty[23:0]; p.other_radius = tr[19:0];
    p.half_width = hw[19:0]; p.half_height = hh[19:0];
    return p;
  endfunction

  // Mostly nearby pairs with modest sizes so that every branch is reached;
  // about one in six is raw noise over the full field ranges.
  function automatic pair_t random_pair();
    pair_t p;
    longint span, ox, oy;
    p.kind = csor_pkg::kind_t'($urandom_range(3, 0));
    if ($urandom_range(5, 0) == 0) begin
      p.own_x = 24'($urandom); p.own_y = 24'($urandom); p.own_radius = 20'($urandom);
      p.other_x = 24'($urandom); p.other_y = 24'($urandom);
      p.other_radius = 20'($urandom);
      p.half_width = 20'($urandom); p.half_height = 20'($urandom);
      if ($urandom_range(3, 0) == 0) p.kind = csor_pkg::KIND_NONE;
    end else begin
      span = 64'sd1 <<< $urandom_range(16, 9);
      ox = longint'($urandom_range(4194304, 0)) - 2097152;
      oy = longint'($urandom_range(4194304, 0)) - 2097152;
      p.own_x = ox[23:0]; p.own_y = oy[23:0];
      p.own_radius = 20'($urandom_range(32'(span), 0));
      p.other_radius = 20'($urandom_range(32'(span), 0));
      p.half_width = 20'($urandom_range(32'(span), 0));
      p.half_height = 20'($urandom_range(32'(span), 0));
      ox = ox + longint'($urandom_range(32'(4 * span), 0)) - 2 * span;
      oy = oy + longint'($urandom_range(32'(4 * span), 0)) - 2 * span;
      p.other_x = ox[23:0]; p.other_y = oy[23:0];
    end
    return p;
  endfunction

  // Driver: a transaction completes at an edge where start was high and busy low.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_pushes.push_back(predict_push(driven_pair));
      void'(pending_pairs.pop_front());
      accepted <= accepted + 1;
    end
    if (rst_n && pending_pairs.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
      driven_pair = pending_pairs[0];
      start <= 1'b1;
      in_kind <= driven_pair.kind;
      in_own_x <= driven_pair.own_x;
      in_own_y <= driven_pair.own_y;
      in_own_radius <= driven_pair.own_radius;
      in_other_x <= driven_pair.other_x;
      in_other_y <= driven_pair.other_y;
      in_other_radius <= driven_pair.other_radius;
      in_other_half_width <= driven_pair.half_width;
      in_other_half_height <= driven_pair.half_height;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    push_t want;
    if (out_valid) begin
      if (expected_pushes.size() == 0) begin
        $error("unexpected result: collided=%0b push_x=%0d push_y=%0d",
               out_collided, out_push_x, out_push_y);
        errors++;
      end else begin
        want = expected_pushes.pop_front();
        if (out_collided !== want.collided) begin
          $error("collided: expected %0b, actual %0b", want.collided, out_collided);
          errors++;
        end
        if (out_push_x !== want.push_x) begin
          $error("push_x: expected %0d, actual %0d", want.push_x, out_push_x);
          errors++;
        end
        if (out_push_y !== want.push_y) begin
          $error("push_y: expected %0d, actual %0d", want.push_y, out_push_y);
          errors++;
        end
        if (want.collided) hits_seen++;
      end
    end
    if (out_valid || (start && !busy) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int phase_pct[4];
    int n;
    phase_pct[0] = 0; phase_pct[1] = 53; phase_pct[2] = 11; phase_pct[3] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pairs: extremes, every kind and the special cases.
    pending_pairs.push_back(make_pair(csor_pkg::KIND_NONE, 8388607, -8388608, 1048575,
                                      -8388608, 8388607, 1048575, 1048575, 1048575));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_CIRCLE, 1000, 2000, 512,
                                      1000, 2000, 256, 0, 0));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_CIRCLE, 300, -400, 600,
                                      0, 0, 600, 0, 0));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_CIRCLE, 8388607, 8388607, 1048575,
                                      8388000, 8388000, 1048575, 0, 0));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_CIRCLE, -8388608, 0, 1048575,
                                      -8388000, 0, 1048575, 0, 0));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_CIRCLE, 8388607, 8388607, 10,
                                      -8388608, -8388608, 10, 0, 0));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_BOX, 100, 0, 512,
                                      0, 0, 0, 2048, 4096));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_BOX, 0, -100, 512,
                                      0, 0, 0, 4096, 2048));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_BOX, 3000, 100, 1024,
                                      0, 0, 0, 2048, 2048));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_BOX, 100, -3000, 1024,
                                      0, 0, 0, 2048, 2048));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_BOX, 2304, 2304, 1024,
                                      0, 0, 0, 2048, 2048));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_BOX, -2400, -2500, 1024,
                                      0, 0, 0, 2048, 2048));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_BOX, 2600, -2600, 1500,
                                      0, 0, 0, 2048, 2048));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_BOX, 9000, 0, 100,
                                      0, 0, 0, 2048, 2048));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_BOX, 8388607, 0, 1048575,
                                      -8388608, 0, 0, 1048575, 1048575));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_BOX, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_TOP, 0, 0, 512,
                                      100, 50, 1024, 0, 0));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_TOP, 0, 0, 512,
                                      100, -1000, 1024, 0, 0));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_TOP, 0, 0, 512,
                                      300, -257, 1024, 0, 0));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_TOP, 0, 0, 512,
                                      0, -256, 1024, 0, 0));
    pending_pairs.push_back(make_pair(csor_pkg::KIND_TOP, -8388608, -8388608, 1048575,
                                      -8000000, -8000000, 1048575, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_pct[ph];
      n = (ph == 0) ? 100 : 117;
      for (int i = 0; i < n; i++) pending_pairs.push_back(random_pair());
      while (pending_pairs.size() != 0) @(posedge clk);
    end
    while (expected_pushes.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);

    $display("Covered %0d shape pairs over four sender idling phases, %0d of them colliding.",
             accepted, hits_seen);
    if (errors == 0 && expected_pushes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
